FILE: rtl/matrix3_inverse_core_assert.svh
// assertion macros for the matrix inverse core
`ifndef MATRIX3_INVERSE_CORE_ASSERT_SVH
`define MATRIX3_INVERSE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define M3I_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define M3I_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/m3i_pkg.sv
// shared types for the matrix inverse core
package m3i_pkg;

    typedef struct packed {
        logic valid;
        logic singular;
    } ctl_t;

    localparam int unsigned ELEMS = 9;

endpackage

FILE: rtl/matrix3_inverse_core.sv
// path from start to done: cofactor front end, divider lanes, merge register
// throughput: one matrix per cycle, busy never rises; the receiver cannot stall
// the nine pipelined dividers compute one quotient bit per stage
// reset: rst_n asynchronous active low clears every valid bit; data is not reset
// top level of the 3x3 matrix inverse core
module matrix3_inverse_core #(
    parameter int unsigned IN_WIDTH  = 16,
    parameter int unsigned OUT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [IN_WIDTH-1:0]  a00,
    input  logic signed [IN_WIDTH-1:0]  a01,
    input  logic signed [IN_WIDTH-1:0]  a02,
    input  logic signed [IN_WIDTH-1:0]  a10,
    input  logic signed [IN_WIDTH-1:0]  a11,
    input  logic signed [IN_WIDTH-1:0]  a12,
    input  logic signed [IN_WIDTH-1:0]  a20,
    input  logic signed [IN_WIDTH-1:0]  a21,
    input  logic signed [IN_WIDTH-1:0]  a22,
    output logic                        done,
    output logic signed [OUT_WIDTH-1:0] r00,
    output logic signed [OUT_WIDTH-1:0] r01,
    output logic signed [OUT_WIDTH-1:0] r02,
    output logic signed [OUT_WIDTH-1:0] r10,
    output logic signed [OUT_WIDTH-1:0] r11,
    output logic signed [OUT_WIDTH-1:0] r12,
    output logic signed [OUT_WIDTH-1:0] r20,
    output logic signed [OUT_WIDTH-1:0] r21,
    output logic signed [OUT_WIDTH-1:0] r22,
    output logic                        singular
);

    `include "matrix3_inverse_core_assert.svh"

    localparam int unsigned LAT = OUT_WIDTH + 8;

    logic signed [IN_WIDTH-1:0]     a_in [m3i_pkg::ELEMS];
    m3i_pkg::ctl_t                  f_ctl;
    logic [2*IN_WIDTH-1:0]          f_adj [m3i_pkg::ELEMS];
    logic [m3i_pkg::ELEMS-1:0]      f_neg;
    logic [3*IN_WIDTH-1:0]          f_det;
    m3i_pkg::ctl_t                  l_ctl [m3i_pkg::ELEMS];
    logic [OUT_WIDTH-1:0]           l_q [m3i_pkg::ELEMS];

    logic                           done_reg;
    logic                           sing_reg;
    logic [OUT_WIDTH-1:0]           r_reg [m3i_pkg::ELEMS];

    assign busy = 1'b0;

    assign a_in[0] = a00;
    assign a_in[1] = a01;
    assign a_in[2] = a02;
    assign a_in[3] = a10;
    assign a_in[4] = a11;
    assign a_in[5] = a12;
    assign a_in[6] = a20;
    assign a_in[7] = a21;
    assign a_in[8] = a22;

    m3i_front #(.IN_W(IN_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .a        (a_in),
        .ctl      (f_ctl),
        .adj_mag  (f_adj),
        .neg      (f_neg),
        .det_mag  (f_det)
    );

    for (genvar k = 0; k < m3i_pkg::ELEMS; k++)
    begin : g_lane
        m3i_lane #(.IN_W(IN_WIDTH), .OUT_W(OUT_WIDTH)) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (f_ctl),
            .num_mag (f_adj[k]),
            .den_mag (f_det),
            .neg_in  (f_neg[k]),
            .ctl_out (l_ctl[k]),
            .q_out   (l_q[k])
        );
    end

    // merge: a singular matrix forces every element to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= l_ctl[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sing_reg <= l_ctl[0].singular;
        for (int k = 0; k < m3i_pkg::ELEMS; k++)
        begin
            r_reg[k] <= l_ctl[k].singular ? '0 : l_q[k];
        end
    end

    assign done     = done_reg;
    assign singular = sing_reg;
    assign r00 = r_reg[0];
    assign r01 = r_reg[1];
    assign r02 = r_reg[2];
    assign r10 = r_reg[3];
    assign r11 = r_reg[4];
    assign r12 = r_reg[5];
    assign r20 = r_reg[6];
    assign r21 = r_reg[7];
    assign r22 = r_reg[8];

    `M3I_CHECK(a_latency, start && !busy, ##LAT done, "result beat missing after start")
    `M3I_CHECK(a_no_extra, done, $past(start && !busy, LAT), "result beat without a start")
    `M3I_CHECK(a_sing_zero, done && singular, r00 == '0 && r11 == '0 && r22 == '0 && r01 == '0 && r12 == '0 && r20 == '0, "singular result not zero")
    `M3I_CHECK_NEXT(a_lane_sync, l_ctl[0].valid, done, "lane beat lost in merge")

endmodule

FILE: rtl/m3i_front.sv
// cofactor and determinant pipeline shared by all lanes
module m3i_front #(
    parameter int unsigned IN_W = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [IN_W-1:0]       a [m3i_pkg::ELEMS],
    output m3i_pkg::ctl_t                ctl,
    output logic [2*IN_W-1:0]            adj_mag [m3i_pkg::ELEMS],
    output logic [m3i_pkg::ELEMS-1:0]    neg,
    output logic [3*IN_W-1:0]            det_mag
);

    localparam int unsigned PW  = 2 * IN_W;
    localparam int unsigned AW  = 2 * IN_W + 1;
    localparam int unsigned DTW = 3 * IN_W + 1;
    localparam int unsigned DW  = 3 * IN_W;

    logic               v_reg [5];
    logic signed [PW-1:0]   p_reg [18];
    logic signed [IN_W-1:0] m1_reg [3];
    logic signed [IN_W-1:0] m2_reg [3];
    logic signed [AW-1:0]   adj2_reg [m3i_pkg::ELEMS];
    logic signed [DTW-1:0]  t_reg [3];
    logic signed [AW-1:0]   adj3_reg [m3i_pkg::ELEMS];
    logic signed [DTW-1:0]  det_reg;
    logic signed [AW-1:0]   adj4_reg [m3i_pkg::ELEMS];
    logic [DW-1:0]          det_mag_reg;
    logic                   sing_reg;
    logic [PW-1:0]          adj_mag_reg [m3i_pkg::ELEMS];
    logic [m3i_pkg::ELEMS-1:0] neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 5; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // two-term products of the cofactors
        p_reg[0]  <= a[4] * a[8];
        p_reg[1]  <= a[5] * a[7];
        p_reg[2]  <= a[2] * a[7];
        p_reg[3]  <= a[1] * a[8];
        p_reg[4]  <= a[1] * a[5];
        p_reg[5]  <= a[2] * a[4];
        p_reg[6]  <= a[5] * a[6];
        p_reg[7]  <= a[3] * a[8];
        p_reg[8]  <= a[0] * a[8];
        p_reg[9]  <= a[2] * a[6];
        p_reg[10] <= a[2] * a[3];
        p_reg[11] <= a[0] * a[5];
        p_reg[12] <= a[3] * a[7];
        p_reg[13] <= a[4] * a[6];
        p_reg[14] <= a[1] * a[6];
        p_reg[15] <= a[0] * a[7];
        p_reg[16] <= a[0] * a[4];
        p_reg[17] <= a[1] * a[3];
        for (int i = 0; i < 3; i++)
        begin
            m1_reg[i] <= a[i];
            m2_reg[i] <= m1_reg[i];
        end

        for (int k = 0; k < m3i_pkg::ELEMS; k++)
        begin
            adj2_reg[k] <= AW'(p_reg[2*k]) - AW'(p_reg[2*k+1]);
        end

        // expansion along row 0 gives the same exact determinant
        t_reg[0] <= m2_reg[0] * adj2_reg[0];
        t_reg[1] <= m2_reg[1] * adj2_reg[3];
        t_reg[2] <= m2_reg[2] * adj2_reg[6];
        adj3_reg <= adj2_reg;

        det_reg  <= t_reg[0] + t_reg[1] + t_reg[2];
        adj4_reg <= adj3_reg;

        det_mag_reg <= det_reg[DTW-1] ? DW'(-det_reg) : DW'(det_reg);
        sing_reg    <= (det_reg == '0);
        for (int k = 0; k < m3i_pkg::ELEMS; k++)
        begin
            adj_mag_reg[k] <= adj4_reg[k][AW-1] ? PW'(-adj4_reg[k]) : PW'(adj4_reg[k]);
            neg_reg[k]     <= adj4_reg[k][AW-1] ^ det_reg[DTW-1];
        end
    end

    assign ctl.valid    = v_reg[4];
    assign ctl.singular = sing_reg;
    assign adj_mag      = adj_mag_reg;
    assign neg          = neg_reg;
    assign det_mag      = det_mag_reg;

endmodule

FILE: rtl/m3i_lane.sv
// one divider lane: pipelined restoring division with saturation
module m3i_lane #(
    parameter int unsigned IN_W  = 16,
    parameter int unsigned OUT_W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  m3i_pkg::ctl_t        ctl_in,
    input  logic [2*IN_W-1:0]    num_mag,
    input  logic [3*IN_W-1:0]    den_mag,
    input  logic                 neg_in,
    output m3i_pkg::ctl_t        ctl_out,
    output logic [OUT_W-1:0]     q_out
);

    localparam int unsigned FRAC = IN_W / 2 + OUT_W / 2;
    localparam int unsigned AMW  = 2 * IN_W;
    localparam int unsigned DW   = 3 * IN_W;
    localparam int unsigned QW   = OUT_W;
    localparam int unsigned NW   = AMW + FRAC;
    localparam int unsigned NXW  = (NW > QW) ? NW : QW + 1;
    localparam int unsigned TW   = NXW - QW;
    localparam int unsigned CW   = (TW > DW) ? TW : DW;

    logic [NXW-1:0] nx;
    logic [TW-1:0]  top;
    logic           ovf;

    m3i_pkg::ctl_t  ctl_reg [QW+1];
    logic           neg_reg [QW+1];
    logic           ovf_reg [QW+1];
    logic [DW-1:0]  den_reg [QW+1];
    logic [DW-1:0]  rem_reg [QW+1];
    logic [QW-1:0]  nlo_reg [QW+1];
    logic [QW-1:0]  q_reg   [QW+1];

    m3i_pkg::ctl_t  out_ctl_reg;
    logic [OUT_W-1:0] out_q_reg;
    logic [OUT_W-1:0] out_q_next;

    assign nx  = NXW'({num_mag, {FRAC{1'b0}}});
    assign top = nx[NXW-1:QW];
    // quotient needs more than QW bits exactly when the top part reaches the divisor
    assign ovf = (CW'(top) >= CW'(den_mag));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= neg_in;
        ovf_reg[0] <= ovf;
        den_reg[0] <= den_mag;
        rem_reg[0] <= DW'(top);
        nlo_reg[0] <= nx[QW-1:0];
        q_reg[0]   <= '0;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        qbit;

        always_comb
        begin
            trial = {rem_reg[i], nlo_reg[i][QW-1]};
            diff  = trial - {1'b0, den_reg[i]};
            qbit  = (trial >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i+1] <= '0;
            end
            else
            begin
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            ovf_reg[i+1] <= ovf_reg[i];
            den_reg[i+1] <= den_reg[i];
            rem_reg[i+1] <= qbit ? diff[DW-1:0] : trial[DW-1:0];
            nlo_reg[i+1] <= {nlo_reg[i][QW-2:0], 1'b0};
            q_reg[i+1]   <= {q_reg[i][QW-2:0], qbit};
        end
    end

    always_comb
    begin
        if (neg_reg[QW])
        begin
            if (ovf_reg[QW] || (q_reg[QW] > {1'b1, {(QW-1){1'b0}}}))
                out_q_next = {1'b1, {(OUT_W-1){1'b0}}};
            else
                out_q_next = OUT_W'(-q_reg[QW]);
        end
        else
        begin
            if (ovf_reg[QW] || q_reg[QW][QW-1])
                out_q_next = {1'b0, {(OUT_W-1){1'b1}}};
            else
                out_q_next = OUT_W'(q_reg[QW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else
        begin
            out_ctl_reg <= ctl_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        out_q_reg <= out_q_next;
    end

    assign ctl_out = out_ctl_reg;
    assign q_out   = out_q_reg;

endmodule

FILE: tb/matrix3_inverse_core_test.sv
// self-checking testbench for the 3x3 fixed-point matrix inverse core
`timescale 1ns / 100ps

module matrix3_inverse_core_test;

    localparam int unsigned IN_W    = 16;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned LATENCY = OUT_W + 8;
    localparam int unsigned N_RAND  = 1750;
    localparam int unsigned CALM    = 200;
    localparam longint      POS_SAT = 64'sd2147483647;
    localparam longint      NEG_SAT = -64'sd2147483648;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef logic signed [IN_W-1:0]  elem_t;
    typedef logic signed [OUT_W-1:0] inv_t;

    typedef struct {
        elem_t a [m3i_pkg::ELEMS];
    } matrix_t;

    typedef struct {
        inv_t r [m3i_pkg::ELEMS];
        logic singular;
    } inverse_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    logic  done;
    logic  singular;
    elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
    inv_t  r00, r01, r02, r10, r11, r12, r20, r21, r22;

    matrix_t  pending_matrices [$];
    inverse_t expected_inverses [$];
    matrix_t  driven_matrix;
    int       idle_left;
    int       error_count;
    int       cycle_count;
    bit       stimulus_loaded;

    matrix3_inverse_core #(
        .IN_WIDTH  (IN_W),
        .OUT_WIDTH (OUT_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .a00      (a00),
        .a01      (a01),
        .a02      (a02),
        .a10      (a10),
        .a11      (a11),
        .a12      (a12),
        .a20      (a20),
        .a21      (a21),
        .a22      (a22),
        .done     (done),
        .r00      (r00),
        .r01      (r01),
        .r02      (r02),
        .r10      (r10),
        .r11      (r11),
        .r12      (r12),
        .r20      (r20),
        .r21      (r21),
        .r22      (r22),
        .singular (singular)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // adj * 2^24 / det, truncated toward zero, saturated to the output range
    function automatic inv_t scaled_quotient(longint adj, longint det);
        logic [63:0] num_mag;
        logic [63:0] den_mag;
        logic [63:0] q;
        bit          neg;
        begin
            neg     = (adj < 0) != (det < 0);
            num_mag = (adj < 0) ? -adj : adj;
            den_mag = (det < 0) ? -det : det;
            q       = (num_mag << (IN_W / 2 + OUT_W / 2)) / den_mag;
            if (neg)
            begin
                if (q > 64'd2147483648)
                    return NEG_SAT;
                return -longint'(q);
            end
            if (q > 64'd2147483647)
                return POS_SAT;
            return q;
        end
    endfunction

    function automatic inverse_t invert_matrix(matrix_t mt);
        longint   m [9];
        longint   adj [9];
        longint   det;
        inverse_t res;
        begin
            for (int i = 0; i < 9; i++)
                m[i] = mt.a[i];
            adj[0] = m[4] * m[8] - m[5] * m[7];
            adj[1] = m[2] * m[7] - m[1] * m[8];
            adj[2] = m[1] * m[5] - m[2] * m[4];
            adj[3] = m[5] * m[6] - m[3] * m[8];
            adj[4] = m[0] * m[8] - m[2] * m[6];
            adj[5] = m[2] * m[3] - m[0] * m[5];
            adj[6] = m[3] * m[7] - m[4] * m[6];
            adj[7] = m[1] * m[6] - m[0] * m[7];
            adj[8] = m[0] * m[4] - m[1] * m[3];
            det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
            res.singular = (det == 0);
            for (int i = 0; i < 9; i++)
                res.r[i] = res.singular ? '0 : scaled_quotient(adj[i], det);
            return res;
        end
    endfunction

    function automatic matrix_t make_matrix(longint v0, longint v1, longint v2,
                                            longint v3, longint v4, longint v5,
                                            longint v6, longint v7, longint v8);
        matrix_t mt;
        begin
            mt.a[0] = v0; mt.a[1] = v1; mt.a[2] = v2;
            mt.a[3] = v3; mt.a[4] = v4; mt.a[5] = v5;
            mt.a[6] = v6; mt.a[7] = v7; mt.a[8] = v8;
            return mt;
        end
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t mt;
        int      kind;
        int      span;
        int      dst_row;
        begin
            kind = $urandom_range(0, 9);
            span = 1 << $urandom_range(1, 15);
            dst_row = $urandom_range(1, 2);
            for (int i = 0; i < 9; i++)
            begin
                if (kind < 4)
                    mt.a[i] = $urandom;
                else
                    mt.a[i] = $urandom_range(0, 2 * span - 1) - span;
            end
            // copied row or column gives a singular matrix
            if (kind == 8)
            begin
                for (int c = 0; c < 3; c++)
                    mt.a[3 * dst_row + c] = mt.a[c];
            end
            else if (kind == 9)
            begin
                for (int r = 0; r < 3; r++)
                    mt.a[3 * r + 2] = mt.a[3 * r];
            end
            return mt;
        end
    endfunction

    // driver: one beat per accepted start, random idle bursts early in the run
    always @(posedge clk or negedge rst_n)
    begin
        matrix_t next_m;
        bit      next_start;
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_inverses.push_back(invert_matrix(driven_matrix));
            next_start = 1'b0;
            if (start && busy)
                next_start = 1'b1;
            else if (idle_left > 0)
                idle_left <= idle_left - 1;
            else if (pending_matrices.size() > 0)
            begin
                next_m = pending_matrices.pop_front();
                driven_matrix = next_m;
                next_start = 1'b1;
                a00 <= next_m.a[0]; a01 <= next_m.a[1]; a02 <= next_m.a[2];
                a10 <= next_m.a[3]; a11 <= next_m.a[4]; a12 <= next_m.a[5];
                a20 <= next_m.a[6]; a21 <= next_m.a[7]; a22 <= next_m.a[8];
                if (pending_matrices.size() > CALM && $urandom_range(0, 5) == 0)
                    idle_left <= $urandom_range(1, 3);
            end
            start <= next_start;
        end
    end

    // monitor: results are accepted whenever done is high
    always @(posedge clk)
    begin
        inverse_t exp_inv;
        inv_t     got [9];
        if (rst_n && done)
        begin
            got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
            if (expected_inverses.size() == 0)
            begin
                $error("result beat with no matrix outstanding");
                error_count++;
            end
            else
            begin
                exp_inv = expected_inverses.pop_front();
                if (singular !== exp_inv.singular)
                begin
                    $error("singular: expected %0d actual %0d", exp_inv.singular, singular);
                    error_count++;
                end
                for (int i = 0; i < 9; i++)
                begin
                    if (got[i] !== exp_inv.r[i])
                    begin
                        $error("r%0d%0d: expected %0d actual %0d", i / 3, i % 3,
                               exp_inv.r[i], got[i]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        start = 1'b0;
        rst_n = 1'b0;
        {a00, a01, a02, a10, a11, a12, a20, a21, a22} = '0;
        error_count = 0;
        cycle_count = 0;
        stimulus_loaded = 0;
        // identity, negated identity, zero, extremes, saturating both ways
        pending_matrices.push_back(make_matrix(256, 0, 0, 0, 256, 0, 0, 0, 256));
        pending_matrices.push_back(make_matrix(-256, 0, 0, 0, -256, 0, 0, 0, -256));
        pending_matrices.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_matrices.push_back(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        pending_matrices.push_back(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        pending_matrices.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_matrices.push_back(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_matrices.push_back(make_matrix(32767, 32766, 0, 32766, 32765, 0, 0, 0, 1));
        pending_matrices.push_back(make_matrix(32767, 32766, 0, 32766, 32765, 0, 0, 0, -1));
        pending_matrices.push_back(make_matrix(-32768, 32767, -32768, 32767, -32768, 32767,
                                               -32768, 32767, 32767));
        pending_matrices.push_back(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                               32767, 32767, 32767));
        pending_matrices.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768,
                                               -32768, -32768, -32768, -32768));
        pending_matrices.push_back(make_matrix(32767, -32768, 0, -32768, 32767, 0,
                                               0, 0, -32768));
        pending_matrices.push_back(make_matrix(0, 256, 0, 0, 0, 256, 256, 0, 0));
        pending_matrices.push_back(make_matrix(512, 256, 0, 256, 512, 256, 0, 256, 512));
        pending_matrices.push_back(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_matrices.push_back(make_matrix(1, 2, 3, 4, 5, 6, 7, 8, 10));
        for (int i = 0; i < N_RAND; i++)
            pending_matrices.push_back(random_matrix());
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_matrices.size() == 0);
        @(posedge clk);
        wait (!start && expected_inverses.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_lane.sv
rtl/matrix3_inverse_core.sv
tb/matrix3_inverse_core_test.sv
